// File: hw/rtl/assert_macros.svh
// Assertion helper macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/twig_pkg.sv
// ---------------------------------------------------------------------------
// twig_pkg
// Shared types and constants of the interval gate.
// ---------------------------------------------------------------------------
`default_nettype none
package twig_pkg;
  localparam int unsigned MaxIntervalsDefault = 256;
  localparam logic [16:0] SecondsPerDay = 17'd86400;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SEAL  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_STOP_LT = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_PHASE   = 3'd5
  } status_t;

  // One queued command from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [63:0] t0;
    logic [63:0] t1;
    logic [63:0] tq;
  } cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/twig_front.sv
// ---------------------------------------------------------------------------
// twig_front
// Accepts input transactions and pushes them into a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none
module twig_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_op,
  input  wire logic [63:0]     in_start_time,
  input  wire logic [63:0]     in_stop_time,
  input  wire logic [63:0]     in_query_time,
  output logic                 q_valid,
  input  wire logic            q_pop,
  output twig_pkg::cmd_t       q_cmd
);
  import twig_pkg::*;

  cmd_t        slot_r [2];
  logic        wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;

  // Queue control.
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ q_pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage; the op is classified on entry.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= '{op: op_t'(in_op), t0: in_start_time,
                          t1: in_stop_time, tq: in_query_time};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/twig_back.sv
// ---------------------------------------------------------------------------
// twig_back
// Executes load, seal and query commands against the interval memory.
// ---------------------------------------------------------------------------
`default_nettype none
module twig_back #(
  parameter int unsigned MAX_INTERVALS = twig_pkg::MaxIntervalsDefault
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_pop,
  input  twig_pkg::cmd_t     q_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_status,
  output logic               out_inside_res,
  output logic [8:0]         out_interval_count,
  output logic [63:0]        out_total_duration
);
  import twig_pkg::*;

  localparam int unsigned AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SORTR = 10'b0000000010,
    S_SORTC = 10'b0000000100,
    S_SORTW = 10'b0000001000,
    S_CHKR  = 10'b0000010000,
    S_CHKC  = 10'b0000100000,
    S_CHKM  = 10'b0001000000,
    S_QRYR  = 10'b0010000000,
    S_QRYC  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  // Interval memory, one read and one write port.
  logic [63:0] start_mem [MAX_INTERVALS];
  logic [63:0] stop_mem  [MAX_INTERVALS];
  logic [63:0] rd_s_r, rd_e_r;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [63:0] wd_s, wd_e;

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wd_s;
      stop_mem[waddr]  <= wd_e;
    end
    rd_s_r <= start_mem[raddr];
    rd_e_r <= stop_mem[raddr];
  end

  state_t      st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        sealed_r, sealed_nxt;
  logic [63:0] dur_r, dur_nxt;
  logic [CW-1:0] i_r, i_nxt;       // outer index / scan index
  logic [CW-1:0] j_r, j_nxt;       // insertion position
  logic [63:0] ks_r, ks_nxt, ke_r, ke_nxt;   // key being inserted / previous stop
  logic [63:0] sum_r, sum_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        hit_r, hit_nxt;
  logic [63:0] tq_r, tq_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] span;
  logic [80:0] prod_full;
  logic [64:0] sum_full;
  logic [2:0]  o_st_r, o_st_nxt;
  logic        o_in_r, o_in_nxt;
  logic        o_v_r, o_v_nxt;

  assign out_valid          = o_v_r;
  assign out_status         = o_st_r;
  assign out_inside_res     = o_in_r;
  assign out_interval_count = 9'(count_r);
  assign out_total_duration = dur_r;

  assign span      = rd_e_r - rd_s_r;
  assign prod_full = span * SecondsPerDay;
  assign sum_full  = {1'b0, sum_r} + {1'b0, prod_r};

  // Sequencer: load and query; seal runs an insertion sort, then a scan with overlap check and sum.
  always_comb begin
    st_nxt = st_r; count_nxt = count_r; sealed_nxt = sealed_r; dur_nxt = dur_r;
    i_nxt = i_r; j_nxt = j_r; ks_nxt = ks_r; ke_nxt = ke_r; sum_nxt = sum_r;
    prod_nxt = prod_r; hit_nxt = hit_r; tq_nxt = tq_r; ov_nxt = ov_r;
    o_st_nxt = o_st_r; o_in_nxt = o_in_r; o_v_nxt = o_v_r;
    q_pop = 1'b0; we = 1'b0; waddr = '0; wd_s = ks_r; wd_e = ke_r;
    raddr = '0;
    if (o_v_r && out_ready) o_v_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_valid && !o_v_r) begin
          q_pop = 1'b1;
          o_in_nxt = 1'b0;
          case (q_cmd.op)
            OP_LOAD: begin
              if (sealed_r) o_st_nxt = ST_PHASE;
              else if (q_cmd.t1 < q_cmd.t0) o_st_nxt = ST_STOP_LT;
              else if (count_r >= CW'(MAX_INTERVALS)) o_st_nxt = ST_FULL;
              else begin
                we = 1'b1; waddr = AW'(count_r); wd_s = q_cmd.t0; wd_e = q_cmd.t1;
                count_nxt = count_r + 1'b1;
                o_st_nxt = ST_OK;
              end
              o_v_nxt = 1'b1;
            end
            OP_SEAL: begin
              if (count_r == '0) begin
                o_st_nxt = ST_EMPTY; o_v_nxt = 1'b1;
              end else begin
                i_nxt = CW'(1); st_nxt = S_SORTR;
              end
            end
            OP_QUERY: begin
              if (!sealed_r) begin
                o_st_nxt = ST_PHASE; o_v_nxt = 1'b1;
              end else begin
                tq_nxt = q_cmd.tq; i_nxt = '0; hit_nxt = 1'b0; st_nxt = S_QRYR;
              end
            end
            default: begin
              o_st_nxt = ST_PHASE; o_v_nxt = 1'b1;
            end
          endcase
        end
      end
      // Fetch key i.
      S_SORTR: begin
        if (i_r >= count_r) begin
          i_nxt = '0; sum_nxt = '0; prod_nxt = '0; ov_nxt = 1'b0; st_nxt = S_CHKR;
        end else begin
          raddr = AW'(i_r); j_nxt = i_r; st_nxt = S_SORTC;
        end
      end
      // Latch key, then read entry j-1.
      S_SORTC: begin
        ks_nxt = rd_s_r; ke_nxt = rd_e_r;
        raddr = AW'(i_r - 1'b1);
        st_nxt = S_SORTW;
      end
      // Compare with entry j-1: shift it up or place the key.
      S_SORTW: begin
        if (j_r != '0 && ((ks_r < rd_s_r) || (ks_r == rd_s_r && ke_r < rd_e_r))) begin
          we = 1'b1; waddr = AW'(j_r); wd_s = rd_s_r; wd_e = rd_e_r;
          j_nxt = j_r - 1'b1;
          raddr = AW'(j_r - 2'd2);
          if (j_r == CW'(1)) begin
            // Reached the bottom; the next compare sees j = 0.
            st_nxt = S_SORTW;
          end
        end else begin
          we = 1'b1; waddr = AW'(j_r);
          i_nxt = i_r + 1'b1; st_nxt = S_SORTR;
        end
      end
      S_CHKR: begin
        raddr = AW'(i_r); st_nxt = S_CHKC;
      end
      // Overlap check, product of the span, and sum of the previous product.
      S_CHKC: begin
        if (i_r != '0 && rd_s_r < ke_r) ov_nxt = 1'b1;
        ke_nxt = rd_e_r;
        prod_nxt = (prod_full[80:64] != '0) ? '1 : prod_full[63:0];
        sum_nxt = sum_full[64] ? '1 : sum_full[63:0];
        st_nxt = S_CHKM;
      end
      S_CHKM: begin
        if (ov_r) begin
          o_st_nxt = ST_OVERLAP; o_v_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (i_r + 1'b1 >= count_r) begin
          dur_nxt = sum_full[64] ? '1 : sum_full[63:0];
          sealed_nxt = 1'b1; o_st_nxt = ST_OK; o_v_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1; st_nxt = S_CHKR;
        end
      end
      S_QRYR: begin
        raddr = AW'(i_r); st_nxt = S_QRYC;
      end
      S_QRYC: begin
        if (tq_r >= rd_s_r && tq_r <= rd_e_r) hit_nxt = 1'b1;
        if (i_r + 1'b1 >= count_r) begin
          st_nxt = S_DONE;
        end else begin
          i_nxt = i_r + 1'b1; raddr = AW'(i_r + 1'b1); st_nxt = S_QRYC;
          if (tq_r >= rd_s_r && tq_r <= rd_e_r) st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        o_st_nxt = ST_OK; o_in_nxt = hit_r; o_v_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; count_r <= '0; sealed_r <= 1'b0; dur_r <= '0; o_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; count_r <= count_nxt; sealed_r <= sealed_nxt;
      dur_r <= dur_nxt; o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; ks_r <= ks_nxt; ke_r <= ke_nxt; sum_r <= sum_nxt;
    prod_r <= prod_nxt; hit_r <= hit_nxt; tq_r <= tq_nxt; ov_r <= ov_nxt;
    o_st_r <= o_st_nxt; o_in_r <= o_in_nxt;
  end
endmodule
`default_nettype wire

// File: hw/rtl/time_window_interval_gate_unit.sv
// A query scans the table entries in order; the scan stops at the first hit.
// Seal: insertion sort plus a per-entry scan that stops at the first overlap.
// The back end handles one item at a time.
// The interval memory, with one read and one write port, sets the scan and sort rates.
// Reset (synchronous, rst_n low) empties the table and clears the sealed flag.
`default_nettype none
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// time_window_interval_gate_unit
// Gates timestamps against a sealed table of good-time intervals.
// ---------------------------------------------------------------------------
module time_window_interval_gate_unit #(
  parameter int unsigned MAX_INTERVALS = twig_pkg::MaxIntervalsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [63:0] in_start_time,
  input  wire logic [63:0] in_stop_time,
  input  wire logic [63:0] in_query_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_inside_res,
  output logic [8:0]       out_interval_count,
  output logic [63:0]      out_total_duration
);
  import twig_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Front end and command queue.
  twig_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_start_time, .in_stop_time,
    .in_query_time, .q_valid, .q_pop, .q_cmd
  );

  // Execution back end.
  twig_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_ready, .out_status,
    .out_inside_res, .out_interval_count, .out_total_duration
  );

  // A popped command always comes from a non-empty queue.
  `ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  // A stalled result holds its status.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_status), "result dropped while stalled")
  // Inside flag only accompanies an ok status.
  `ASSERT_IMPL(a_inside_ok, clk, rst_n, out_valid && out_inside_res,
               out_status == ST_OK, "inside set with error status")
endmodule
`default_nettype wire

// File: tb/sv/time_window_interval_gate_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// time_window_interval_gate_unit_tb
// Loads a table of disjoint good-time intervals in shuffled order, with
// rejected items mixed in, fills the table, seals it and then gates random
// and boundary timestamps against it. Each result is checked field by field,
// in order, against a behavioral copy of the gate or a directed row's value.
// ---------------------------------------------------------------------------
module time_window_interval_gate_unit_tb;
  import twig_pkg::*;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned QueryCount = 320;
  localparam int unsigned QuietTail = 60;

  typedef struct packed {
    status_t     st;
    logic        hit;
    logic [8:0]  cnt;
    logic [63:0] dur;
  } gate_result_t;

  typedef struct {
    op_t          op;
    logic [63:0]  t0;
    logic [63:0]  t1;
    logic [63:0]  tq;
    bit           typed;
    gate_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [63:0] in_start_time;
  logic [63:0] in_stop_time;
  logic [63:0] in_query_time;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic        out_inside_res;
  logic [8:0]  out_interval_count;
  logic [63:0] out_total_duration;

  // Shadow state of the gate.
  logic [63:0] gate_start [TableDepth];
  logic [63:0] gate_stop [TableDepth];
  int unsigned gate_count;
  bit          gate_sealed;
  logic [63:0] gate_duration;

  // Interval set used as stimulus, disjoint by construction.
  logic [63:0] iv_start [TableDepth];
  logic [63:0] iv_stop [TableDepth];

  gate_result_t expected_results[$];
  gate_result_t drv_want;
  gate_result_t got;
  gate_result_t head;
  bit           drv_typed;
  bit           quiet;
  int unsigned  mismatches;
  int unsigned  cycle_count;

  time_window_interval_gate_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_start_time     (in_start_time),
    .in_stop_time      (in_stop_time),
    .in_query_time     (in_query_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_inside_res    (out_inside_res),
    .out_interval_count(out_interval_count),
    .out_total_duration(out_total_duration)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Appends the expected result of one accepted transaction.
  function automatic void enqueue_result(gate_result_t r);
    expected_results = {expected_results, r};
  endfunction

  // Sorts the shadow table by start, then stop, keeping equal entries stable.
  function automatic void sort_shadow();
    logic [63:0] s;
    logic [63:0] e;
    int          j;
    for (int i = 1; i < gate_count; i++) begin
      s = gate_start[i];
      e = gate_stop[i];
      j = i;
      while (j > 0 && (s < gate_start[j-1] || (s == gate_start[j-1] && e < gate_stop[j-1])))
      begin
        gate_start[j] = gate_start[j-1];
        gate_stop[j] = gate_stop[j-1];
        j--;
      end
      gate_start[j] = s;
      gate_stop[j] = e;
    end
  endfunction

  // Seal: sort, check neighbors and sum the lengths in seconds, saturating.
  function automatic status_t seal_shadow();
    logic [127:0] prod;
    logic [64:0]  acc;
    if (gate_count == 0) return ST_EMPTY;
    sort_shadow();
    acc = '0;
    for (int i = 0; i < gate_count; i++) begin
      if (i > 0 && gate_start[i] < gate_stop[i-1]) return ST_OVERLAP;
      prod = (gate_stop[i] - gate_start[i]) * 128'(SecondsPerDay);
      if (prod[127:64] != 0) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      else acc = acc + {1'b0, prod[63:0]};
      if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    gate_duration = acc[63:0];
    gate_sealed = 1'b1;
    return ST_OK;
  endfunction

  // Applies one transaction to the shadow state and returns its result.
  function automatic gate_result_t gate_predict(logic [1:0] op, logic [63:0] t0,
                                                logic [63:0] t1, logic [63:0] tq);
    gate_result_t r;
    r.st = ST_PHASE;
    r.hit = 1'b0;
    case (op)
      OP_LOAD: begin
        if (gate_sealed) r.st = ST_PHASE;
        else if (t1 < t0) r.st = ST_STOP_LT;
        else if (gate_count >= TableDepth) r.st = ST_FULL;
        else begin
          gate_start[gate_count] = t0;
          gate_stop[gate_count] = t1;
          gate_count++;
          r.st = ST_OK;
        end
      end
      OP_SEAL: r.st = seal_shadow();
      OP_QUERY: begin
        if (gate_sealed) begin
          r.st = ST_OK;
          for (int i = 0; i < gate_count; i++)
            if (tq >= gate_start[i] && tq <= gate_stop[i]) r.hit = 1'b1;
        end
      end
      default: r.st = ST_PHASE;
    endcase
    r.cnt = 9'(gate_count);
    r.dur = gate_duration;
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h, got %0h (cycle %0d)", what, want, seen, cycle_count);
  endfunction

  // Result checking and prediction at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{status_t'(out_status), out_inside_res, out_interval_count, out_total_duration};
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transaction, status", 64'hX, 64'(out_status));
        end else begin
          head = expected_results.pop_front();
          if (got.st !== head.st) note_mismatch("status", 64'(head.st), 64'(got.st));
          if (got.hit !== head.hit)
            note_mismatch("inside_res", 64'(head.hit), 64'(got.hit));
          if (got.cnt !== head.cnt) note_mismatch("interval_count", 64'(head.cnt), 64'(got.cnt));
          if (got.dur !== head.dur) note_mismatch("total_duration", head.dur, got.dur);
        end
      end
      if (in_valid && in_ready) begin
        head = gate_predict(in_op, in_start_time, in_stop_time, in_query_time);
        enqueue_result(drv_typed ? drv_want : head);
      end
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Result side stalls in random bursts.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  // Presents one transaction and returns at the falling edge after acceptance.
  task automatic send_txn(logic [1:0] op, logic [63:0] t0, logic [63:0] t1, logic [63:0] tq,
                          bit typed = 1'b0, gate_result_t want = '0);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_op = op;
    in_start_time = t0;
    in_stop_time = t1;
    in_query_time = tq;
    drv_typed = typed;
    drv_want = want;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // A rejected load with stop strictly before start.
  task automatic send_backward_load();
    logic [63:0] a;
    logic [63:0] b;
    a = rand64();
    b = rand64();
    if (a == b) b = a + 1;
    if (a < b) send_txn(OP_LOAD, b, a, rand64());
    else send_txn(OP_LOAD, a, b, rand64());
  endtask

  // Transactions that change nothing in the current phase.
  task automatic send_noise(bit after_seal);
    case ($urandom_range(0, 2))
      0: send_txn(OP_NONE, rand64(), rand64(), rand64());
      1: if (after_seal) send_txn(OP_LOAD, 64'd0, rand64(), rand64());
         else send_txn(OP_QUERY, rand64(), rand64(), rand64());
      default: if (after_seal) send_txn(OP_SEAL, rand64(), rand64(), rand64());
               else send_backward_load();
    endcase
  endtask

  initial begin
    stim_row_t   rows [11];
    int          pool[$];
    bit          touch;
    logic [63:0] base;
    logic [63:0] qt;
    int          k;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_NONE;
    in_start_time = '0;
    in_stop_time = '0;
    in_query_time = '0;
    drv_typed = 1'b0;
    drv_want = '0;
    quiet = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    gate_count = 0;
    gate_sealed = 1'b0;
    gate_duration = '0;

    // Disjoint intervals, one per 2^56 slot; some touch, one has zero length.
    touch = 1'b0;
    for (int i = 0; i < TableDepth; i++) begin
      base = 64'(i) << 56;
      if (i == 0) iv_start[i] = '0;
      else if (touch) iv_start[i] = base;
      else iv_start[i] = base + (rand64() & 64'h007F_FFFF_FFFF_FFFF);
      touch = 1'b0;
      if (i == TableDepth - 1) iv_stop[i] = '1;
      else if (i == 100) iv_stop[i] = iv_start[i];
      else if (i % 8 == 0) begin
        iv_stop[i] = base + (64'd1 << 56);
        touch = 1'b1;
      end else iv_stop[i] = iv_start[i] + (rand64() & 64'h003F_FFFF_FFFF_FFFF);
    end

    // Directed rows: wrong phase, empty table, unused op, reversed limits, extremes.
    rows[0] = '{OP_QUERY, '0, '0, 64'd5, 1'b1, '{ST_PHASE, 1'b0, 9'd0, 64'd0}};
    rows[1] = '{OP_SEAL, '0, '0, '0, 1'b1, '{ST_EMPTY, 1'b0, 9'd0, 64'd0}};
    rows[2] = '{OP_NONE, '1, '1, '1, 1'b1, '{ST_PHASE, 1'b0, 9'd0, 64'd0}};
    rows[3] = '{OP_LOAD, '1, '0, '0, 1'b1, '{ST_STOP_LT, 1'b0, 9'd0, 64'd0}};
    rows[4] = '{OP_LOAD, 64'd1, 64'd0, '1, 1'b1, '{ST_STOP_LT, 1'b0, 9'd0, 64'd0}};
    rows[5] = '{OP_LOAD, iv_start[255], iv_stop[255], '0, 1'b0, '0};
    rows[6] = '{OP_LOAD, iv_start[0], iv_stop[0], '0, 1'b0, '0};
    rows[7] = '{OP_LOAD, iv_start[100], iv_stop[100], '0, 1'b0, '0};
    rows[8] = '{OP_LOAD, iv_start[9], iv_stop[9], '0, 1'b0, '0};
    rows[9] = '{OP_LOAD, iv_start[8], iv_stop[8], '0, 1'b0, '0};
    rows[10] = '{OP_QUERY, '0, '0, iv_start[8], 1'b0, '0};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    foreach (rows[i])
      send_txn(rows[i].op, rows[i].t0, rows[i].t1, rows[i].tq, rows[i].typed, rows[i].want);

    // Fill the rest of the table in shuffled order, with rejected items mixed in.
    for (int i = 1; i < TableDepth - 1; i++)
      if (i != 8 && i != 9 && i != 100) pool = {pool, i};
    pool.shuffle();
    foreach (pool[i]) begin
      if ($urandom_range(0, 6) == 0) send_noise(1'b0);
      send_txn(OP_LOAD, iv_start[pool[i]], iv_stop[pool[i]], rand64());
    end

    // Full table: a good load is refused, a reversed one still reports its order first.
    send_txn(OP_LOAD, iv_start[3], iv_stop[3], '0);
    send_backward_load();
    send_txn(OP_LOAD, '0, '1, '0);

    // Seal twice, then gate timestamps.
    send_txn(OP_SEAL, '0, '0, '0);
    send_txn(OP_SEAL, '1, '1, '1);
    for (int n = 0; n < QueryCount; n++) begin
      if (n == QueryCount - QuietTail) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) send_noise(1'b1);
      k = $urandom_range(0, TableDepth - 1);
      case ($urandom_range(0, 5))
        0: qt = rand64();
        1: qt = iv_start[k];
        2: qt = iv_stop[k];
        3: qt = iv_start[k] - 1;
        4: qt = iv_stop[k] + 1;
        default: qt = iv_start[k] + ((iv_stop[k] - iv_start[k]) >> 1);
      endcase
      send_txn(OP_QUERY, rand64(), rand64(), qt);
    end
    in_valid = 1'b0;

    // Drain, then wait for any unexpected result.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
